// ===== hdl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sequential list engine: command and
// status codes, and the request and response beat layouts.
// ----------------------------------------------------------------------------
package sle_pkg;

    // default number of list entries
    localparam int SLE_CAPACITY = 128;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // request beat
    typedef struct packed {
        cmd_t               cmd;
        logic [7:0]         position;
        logic signed [31:0] value;
    } sle_req_t;

    // response beat
    typedef struct packed {
        status_t            status;
        logic [6:0]         found_index;
        logic signed [31:0] read_value;
        logic [7:0]         list_length;
        logic               is_empty;
    } sle_rsp_t;

endpackage

// ===== hdl/sle_req_if.sv =====
// ----------------------------------------------------------------------------
// sle_req_if
// Valid/ready channel carrying list commands into the engine.
// ----------------------------------------------------------------------------
interface sle_req_if;

    logic              valid;
    logic              ready;
    sle_pkg::sle_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== hdl/sle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sle_rsp_if
// Valid/ready channel carrying one result beat per command out of the engine.
// ----------------------------------------------------------------------------
interface sle_rsp_if;

    logic              valid;
    logic              ready;
    sle_pkg::sle_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== hdl/sle_ram.sv =====
// ----------------------------------------------------------------------------
// sle_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/sequential_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sequential_list_engine_unit
// Packed ordered list of signed 32-bit entries held in one RAM, with insert,
// delete, find and read commands.
// ----------------------------------------------------------------------------
// Usage:
//   request  : one beat per command (cmd, position, value).
//   response : exactly one beat per command (status, found_index, read_value,
//              list_length, is_empty), in command order.
//   One command is worked on at a time; request.ready is high only when the
//   engine is idle. An insert moves each entry from the end down to position p
//   up by one and then writes the value into the gap; a delete moves each
//   entry after position p down by one; a find compares entries from index
//   zero until a match or the end of the list; a read fetches one entry.
//   Every entry moved or compared uses the single RAM port pair (one read,
//   one write per cycle); the read data is registered.
//   The response sits in an output register. A new command is taken while it
//   waits; if the receiver still stalls when that command finishes, its
//   result is parked and the engine stops taking beats until it drains.
//   Reset empties the list (length zero), drops response.valid and leaves
//   the engine idle; the RAM contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module sequential_list_engine_unit #(
    parameter int CAPACITY = sle_pkg::SLE_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    sle_req_if.sink   request,
    sle_rsp_if.source response
);

    import sle_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INS   = 7'b0000010,
        S_DEL   = 7'b0000100,
        S_FIND  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_REPLY = 7'b0100000,
        S_HOLD  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [7:0]         pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;
    status_t            status_reg, status_next;
    sle_rsp_t           hold_reg, hold_next;
    sle_rsp_t           rsp_reg;
    logic               rsp_valid_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    logic               out_free;
    logic               out_load;
    sle_rsp_t           out_data;
    logic               fin;
    status_t            fin_status;
    logic [CW-1:0]      fin_found;
    logic [31:0]        fin_read;
    sle_rsp_t           fin_rsp;
    logic [XW-1:0]      pos_x, cnt_x, len_x, found_x;

    // entry storage
    sle_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign request.ready    = (state_reg == S_IDLE);
    assign response.valid   = rsp_valid_reg;
    assign response.payload = rsp_reg;
    assign out_free         = !rsp_valid_reg || response.ready;

    assign pos_x = XW'(request.payload.position);
    assign cnt_x = XW'(cnt_reg);

    // result beat assembly
    assign len_x   = XW'(cnt_next);
    assign found_x = XW'(fin_found);
    always_comb
    begin
        fin_rsp.status      = fin_status;
        fin_rsp.found_index = found_x[6:0];
        fin_rsp.read_value  = fin_read;
        fin_rsp.list_length = len_x[7:0];
        fin_rsp.is_empty    = (cnt_next == '0);
    end

    // command sequencer: read and, for insert and delete, write back one entry per cycle
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;
        hold_next   = hold_reg;
        ram_we      = 1'b0;
        ram_waddr   = AW'(idx_reg);
        ram_wdata   = ram_rdata;
        ram_raddr   = '0;
        fin         = 1'b0;
        fin_status  = ST_OK;
        fin_found   = '0;
        fin_read    = '0;
        out_load    = 1'b0;
        out_data    = hold_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    pos_next    = request.payload.position;
                    val_next    = request.payload.value;
                    status_next = ST_BAD_POS;
                    unique case (request.payload.cmd)
                        CMD_INSERT:
                        begin
                            if (pos_x > cnt_x)
                            begin
                                state_next = S_REPLY;
                            end
                            else if (cnt_x == XW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_REPLY;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                ram_raddr  = AW'(cnt_reg - CW'(1));
                                state_next = S_INS;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                idx_next   = CW'(request.payload.position);
                                ram_raddr  = AW'(pos_x + XW'(1));
                                state_next = S_DEL;
                            end
                        end
                        CMD_FIND:
                        begin
                            idx_next   = '0;
                            ram_raddr  = '0;
                            state_next = S_FIND;
                        end
                        CMD_READ:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                ram_raddr  = AW'(request.payload.position);
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_reg);
                if (XW'(idx_reg) == XW'(pos_reg))
                begin
                    // gap reached: drop the new value in
                    ram_wdata = val_reg;
                    cnt_next  = cnt_reg + CW'(1);
                    fin       = 1'b1;
                end
                else
                begin
                    idx_next  = idx_reg - CW'(1);
                    ram_raddr = AW'(idx_reg - CW'(2));
                end
            end
            S_DEL:
            begin
                if (idx_reg + CW'(1) == cnt_reg)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    fin      = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(idx_reg);
                    idx_next  = idx_reg + CW'(1);
                    ram_raddr = AW'(idx_reg + CW'(2));
                end
            end
            S_FIND:
            begin
                if (idx_reg == cnt_reg)
                begin
                    fin_status = ST_NOT_FOUND;
                    fin        = 1'b1;
                end
                else if (ram_rdata == val_reg)
                begin
                    fin_found = idx_reg;
                    fin       = 1'b1;
                end
                else
                begin
                    idx_next  = idx_reg + CW'(1);
                    ram_raddr = AW'(idx_reg + CW'(1));
                end
            end
            S_READ:
            begin
                fin_read = ram_rdata;
                fin      = 1'b1;
            end
            S_REPLY:
            begin
                fin_status = status_reg;
                fin        = 1'b1;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the finished result to the output register or park it
        if (fin)
        begin
            if (out_free)
            begin
                out_load   = 1'b1;
                out_data   = fin_rsp;
                state_next = S_IDLE;
            end
            else
            begin
                hold_next  = fin_rsp;
                state_next = S_HOLD;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        hold_reg   <= hold_next;
        if (out_load)
        begin
            rsp_reg <= out_data;
        end
    end

endmodule

// ===== hdl/sle_checker.sv =====
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input sle_pkg::sle_rsp_t rsp_payload
);

    import sle_pkg::*;

    logic       req_fire;
    logic       rsp_fire;
    logic [7:0] last_len_reg;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // length reported by the previous response beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_len_reg <= '0;
        end
        else if (rsp_fire)
        begin
            last_len_reg <= rsp_payload.list_length;
        end
    end

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("response beat changed under stall");

    // one command in flight: no beat taken the cycle after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("request taken while busy");

    // length moves by at most one per command
    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire |-> (rsp_payload.list_length == last_len_reg)
                  || (rsp_payload.list_length == last_len_reg + 8'd1)
                  || (rsp_payload.list_length + 8'd1 == last_len_reg))
        else $error("length jumped");

    // a refused command or a find with no match leaves the length alone
    a_len_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && rsp_payload.status != ST_OK
        |-> rsp_payload.list_length == last_len_reg)
        else $error("length changed on a failed command");

endmodule

bind sequential_list_engine_unit sle_checker u_sle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .rsp_valid   (response.valid),
    .rsp_ready   (response.ready),
    .rsp_payload (response.payload)
);
